// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OGM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OGM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/ogm_pkg.sv -----
// ----------------------------------------------------------------------------
// ogm_pkg
// Types, codes and arithmetic helpers of the occupancy grid update merger.
// ----------------------------------------------------------------------------
package ogm_pkg;

	localparam int IDX_W  = 16;
	localparam int VAL_W  = 16;
	localparam int INC_W  = 9;
	localparam int CELL_W = 8;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] KIND_EMPTY  = 2'd0;
	localparam logic [1:0] KIND_FULL   = 2'd1;
	localparam logic [1:0] KIND_COMMIT = 2'd2;
	localparam logic [1:0] KIND_READ   = 2'd3;

	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_MERGED  = 3'd1;
	localparam logic [2:0] ST_DROPPED = 3'd2;
	localparam logic [2:0] ST_COMMIT  = 3'd3;
	localparam logic [2:0] ST_READ    = 3'd4;

	localparam logic [1:0] REG_EMPTY_INC  = 2'd0;
	localparam logic [1:0] REG_REPEAT_INC = 2'd1;
	localparam logic [1:0] REG_FULL_INC   = 2'd2;

	localparam logic signed [INC_W-1:0] EMPTY_INC_RST  = -9'sd2;
	localparam logic signed [INC_W-1:0] REPEAT_INC_RST = -9'sd2;
	localparam logic signed [INC_W-1:0] FULL_INC_RST   = 9'sd10;

	localparam logic signed [VAL_W:0]   PEND_MAX = 17'sd32767;
	localparam logic signed [VAL_W:0]   PEND_MIN = -17'sd32768;
	localparam logic signed [VAL_W+1:0] CELL_MAX = 18'sd255;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_MARK  = 6'b000100,
		S_READ  = 6'b001000,
		S_CM_RD = 6'b010000,
		S_CM_WR = 6'b100000
	} state_t;

	typedef struct packed {
		logic                    upd;
		logic                    is_full;
		logic [IDX_W-1:0]        idx;
		logic signed [INC_W-1:0] new_inc;
		logic signed [INC_W-1:0] rep_inc;
		logic signed [INC_W-1:0] hit_inc;
	} cell_ctl_t;

	function automatic logic signed [VAL_W-1:0] sat_add(
		input logic signed [VAL_W-1:0] a,
		input logic signed [INC_W-1:0] b
	);
		logic signed [VAL_W:0] s;
		s = (VAL_W+1)'(a) + (VAL_W+1)'(b);
		if (s > PEND_MAX) begin
			s = PEND_MAX;
		end else if (s < PEND_MIN) begin
			s = PEND_MIN;
		end
		return s[VAL_W-1:0];
	endfunction

	function automatic logic [CELL_W-1:0] clamp_cell(
		input logic [CELL_W-1:0]       cur,
		input logic signed [VAL_W-1:0] inc
	);
		logic signed [VAL_W+1:0] s;
		s = $signed({{(VAL_W+2-CELL_W){1'b0}}, cur}) + (VAL_W+2)'(inc);
		if (s < 0) begin
			s = '0;
		end else if (s > CELL_MAX) begin
			s = CELL_MAX;
		end
		return s[CELL_W-1:0];
	endfunction

endpackage

// ----- src/ogm_cell.sv -----
// ----------------------------------------------------------------------------
// ogm_cell
// One pending-update slot: holds a cell index and its signed increment,
// matches against the broadcast index and shifts toward the head on commit.
// ----------------------------------------------------------------------------
module ogm_cell (
	input  logic                           clk,
	input  ogm_pkg::cell_ctl_t             ctl,
	input  logic                           occupied,
	input  logic                           load,
	input  logic                           shift,
	input  logic [ogm_pkg::IDX_W-1:0]      nxt_index,
	input  logic signed [ogm_pkg::VAL_W-1:0] nxt_value,
	output logic [ogm_pkg::IDX_W-1:0]      index,
	output logic signed [ogm_pkg::VAL_W-1:0] value,
	output logic                           match
);
	import ogm_pkg::*;

	logic [IDX_W-1:0]        index_q;
	logic signed [VAL_W-1:0] value_q;
	logic signed [VAL_W-1:0] upd_value;

	assign index = index_q;
	assign value = value_q;
	assign match = occupied && (index_q == ctl.idx);

	always_comb begin
		upd_value = value_q;
		if (ctl.is_full) begin
			if (value_q < 0) begin
				upd_value = VAL_W'(ctl.hit_inc);
			end else begin
				upd_value = sat_add(value_q, ctl.hit_inc);
			end
		end else if (value_q <= 0) begin
			upd_value = sat_add(value_q, ctl.rep_inc);
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			index_q <= nxt_index;
			value_q <= nxt_value;
		end else if (load) begin
			index_q <= ctl.idx;
			value_q <= VAL_W'(ctl.new_inc);
		end else if (ctl.upd && match) begin
			value_q <= upd_value;
		end
	end

endmodule

// ----- src/ogm_map_mem.sv -----
// ----------------------------------------------------------------------------
// ogm_map_mem
// Map cell store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module ogm_map_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [ogm_pkg::CELL_W-1:0]  wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [ogm_pkg::CELL_W-1:0]  rdata
);
	import ogm_pkg::*;

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// ----- src/occupancy_grid_update_merger_unit.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_update_merger_unit
// Merges mark-empty and mark-full events into a row of pending-update cells
// and commits them into the 8-bit occupancy map.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  in        sink       in_valid / in_ready    kind, cell_index
//  out       source     out_valid / out_ready  status, out_index, cell_value,
//                                              nothing_pending, last
//  apb       sink       psel, penable, pready  paddr, pwdata, prdata
//
// A mark or a read is first accepted, then searches the cells or reads the
// map. A commit is first accepted, then for each pending cell does a
// registered map read followed by the write back; when nothing is pending
// it gives a single empty commit result.
// After reset the map is cleared one cell a cycle, MAP_CELLS cells in all
// (at most 65536); no item is accepted meanwhile.
// A stalled result waits in the output register; the next item is accepted.
// ----------------------------------------------------------------------------
module occupancy_grid_update_merger_unit #(
	parameter int MAP_CELLS    = 65536,
	parameter int UPDATE_SLOTS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ogm_pkg::ADDR_W-1:0]   paddr,
	input  logic [ogm_pkg::DATA_W-1:0]   pwdata,
	output logic [ogm_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   kind,
	input  logic [ogm_pkg::IDX_W-1:0]    cell_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   status,
	output logic [ogm_pkg::IDX_W-1:0]    out_index,
	output logic [ogm_pkg::CELL_W-1:0]   cell_value,
	output logic                         nothing_pending,
	output logic                         last
);
	import ogm_pkg::*;

	localparam int MAP_DEPTH = (MAP_CELLS > 65536) ? 65536 : MAP_CELLS;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);
	localparam int CNT_W     = $clog2(UPDATE_SLOTS + 1);

	state_t                  state_q;
	logic [MAP_AW-1:0]       clr_q;
	logic [CNT_W-1:0]        count_q;
	logic [1:0]              kind_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [INC_W-1:0] empty_inc_q;
	logic signed [INC_W-1:0] rep_inc_q;
	logic signed [INC_W-1:0] hit_inc_q;

	logic                    out_valid_q;
	logic [2:0]              status_q;
	logic [IDX_W-1:0]        out_index_q;
	logic [CELL_W-1:0]       cell_value_q;
	logic                    none_q;
	logic                    last_q;

	logic [IDX_W-1:0]        c_index [UPDATE_SLOTS];
	logic signed [VAL_W-1:0] c_value [UPDATE_SLOTS];
	logic [UPDATE_SLOTS-1:0] c_match;

	cell_ctl_t               ctl;
	logic                    cfg_wr;
	logic [1:0]              reg_sel;
	logic                    in_fire;
	logic                    out_free;
	logic                    in_range;
	logic                    found;
	logic                    buf_full;
	logic                    mark_go;
	logic                    read_go;
	logic                    cm_empty;
	logic                    cm_emit;
	logic                    do_upd;
	logic                    do_load;
	logic [CELL_W-1:0]       new_cell;
	logic                    mem_we;
	logic [MAP_AW-1:0]       mem_waddr;
	logic [CELL_W-1:0]       mem_wdata;
	logic                    mem_re;
	logic [MAP_AW-1:0]       mem_raddr;
	logic [CELL_W-1:0]       mem_rdata;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];

	always_comb begin
		case (reg_sel)
			REG_EMPTY_INC:  prdata = DATA_W'(empty_inc_q);
			REG_REPEAT_INC: prdata = DATA_W'(rep_inc_q);
			REG_FULL_INC:   prdata = DATA_W'(hit_inc_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_inc_q <= EMPTY_INC_RST;
			rep_inc_q   <= REPEAT_INC_RST;
			hit_inc_q   <= FULL_INC_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_EMPTY_INC:  empty_inc_q <= pwdata[INC_W-1:0];
				REG_REPEAT_INC: rep_inc_q   <= pwdata[INC_W-1:0];
				REG_FULL_INC:   hit_inc_q   <= pwdata[INC_W-1:0];
				default:        ;
			endcase
		end
	end

	// Control.
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign in_range = ({16'b0, idx_q} < 32'(MAP_CELLS));
	assign found    = |c_match;
	assign buf_full = (count_q == CNT_W'(UPDATE_SLOTS));
	assign mark_go  = (state_q == S_MARK) && out_free;
	assign read_go  = (state_q == S_READ) && out_free;
	assign cm_empty = (state_q == S_CM_RD) && (count_q == '0) && out_free;
	assign cm_emit  = (state_q == S_CM_WR) && out_free;
	assign do_upd   = mark_go && in_range && found;
	assign do_load  = mark_go && in_range && !found && !buf_full;
	assign new_cell = clamp_cell(mem_rdata, c_value[0]);

	always_comb begin
		ctl.upd      = do_upd;
		ctl.is_full  = (kind_q == KIND_FULL);
		ctl.idx      = idx_q;
		ctl.new_inc  = (kind_q == KIND_FULL) ? hit_inc_q : empty_inc_q;
		ctl.rep_inc  = rep_inc_q;
		ctl.hit_inc  = hit_inc_q;
	end

	// Pending-update cells; the head sits at slot zero.
	for (genvar g = 0; g < UPDATE_SLOTS; g++) begin : g_cell
		logic [IDX_W-1:0]        nxt_index;
		logic signed [VAL_W-1:0] nxt_value;

		if (g == UPDATE_SLOTS - 1) begin : g_tail
			assign nxt_index = c_index[g];
			assign nxt_value = c_value[g];
		end else begin : g_body
			assign nxt_index = c_index[g+1];
			assign nxt_value = c_value[g+1];
		end

		ogm_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (CNT_W'(g) < count_q),
			.load      (do_load && (count_q == CNT_W'(g))),
			.shift     (cm_emit),
			.nxt_index (nxt_index),
			.nxt_value (nxt_value),
			.index     (c_index[g]),
			.value     (c_value[g]),
			.match     (c_match[g])
		);
	end

	// Map store.
	always_comb begin
		mem_we    = (state_q == S_CLEAR) || cm_emit;
		mem_waddr = (state_q == S_CLEAR) ? clr_q : c_index[0][MAP_AW-1:0];
		mem_wdata = (state_q == S_CLEAR) ? '0 : new_cell;
		mem_re    = (in_fire && (kind == KIND_READ))
		            || ((state_q == S_CM_RD) && (count_q != '0));
		mem_raddr = (state_q == S_IDLE) ? cell_index[MAP_AW-1:0]
		                                : c_index[0][MAP_AW-1:0];
	end

	ogm_map_mem #(
		.DEPTH (MAP_DEPTH),
		.AW    (MAP_AW)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + MAP_AW'(1);
					if (clr_q == MAP_AW'(MAP_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						case (kind)
							KIND_EMPTY, KIND_FULL: state_q <= S_MARK;
							KIND_COMMIT:           state_q <= S_CM_RD;
							KIND_READ:             state_q <= S_READ;
							default:               state_q <= S_IDLE;
						endcase
					end
				end
				S_MARK: begin
					if (mark_go) begin
						state_q <= S_IDLE;
					end
					if (do_load) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				S_READ: begin
					if (read_go) begin
						state_q <= S_IDLE;
					end
				end
				S_CM_RD: begin
					if (count_q != '0) begin
						state_q <= S_CM_WR;
					end else if (cm_empty) begin
						state_q <= S_IDLE;
					end
				end
				S_CM_WR: begin
					if (cm_emit) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= (count_q == CNT_W'(1)) ? S_IDLE : S_CM_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= kind;
			idx_q  <= cell_index;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (mark_go || read_go || cm_empty || cm_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mark_go) begin
			if (!in_range || (!found && buf_full)) begin
				status_q <= ST_DROPPED;
			end else if (found) begin
				status_q <= ST_MERGED;
			end else begin
				status_q <= ST_NEW;
			end
			out_index_q  <= idx_q;
			cell_value_q <= '0;
			none_q       <= 1'b0;
			last_q       <= 1'b1;
		end else if (read_go) begin
			status_q     <= ST_READ;
			out_index_q  <= idx_q;
			cell_value_q <= in_range ? mem_rdata : '0;
			none_q       <= 1'b0;
			last_q       <= 1'b1;
		end else if (cm_empty) begin
			status_q     <= ST_COMMIT;
			out_index_q  <= '0;
			cell_value_q <= '0;
			none_q       <= 1'b1;
			last_q       <= 1'b1;
		end else if (cm_emit) begin
			status_q     <= ST_COMMIT;
			out_index_q  <= c_index[0];
			cell_value_q <= new_cell;
			none_q       <= 1'b0;
			last_q       <= (count_q == CNT_W'(1));
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign out_index       = out_index_q;
	assign cell_value      = cell_value_q;
	assign nothing_pending = none_q;
	assign last            = last_q;

endmodule

// ----- src/ogm_checker.sv -----
// ----------------------------------------------------------------------------
// ogm_checker
// Port-level checks on the result channel of the update merger.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ogm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [2:0]                  status,
	input logic [ogm_pkg::IDX_W-1:0]   out_index,
	input logic [ogm_pkg::CELL_W-1:0]  cell_value,
	input logic                        nothing_pending,
	input logic                        last
);
	import ogm_pkg::*;

	`OGM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(out_index) && $stable(cell_value) && $stable(last), "Stalled item changed.")

	`OGM_ASSERT_NOW(a_single_last, out_valid && (status != ST_COMMIT), last, "Non-commit item without last.")

	`OGM_ASSERT_NOW(a_empty_commit, out_valid && nothing_pending, (status == ST_COMMIT) && last && (cell_value == '0) && (out_index == '0), "Malformed empty commit item.")

	`OGM_ASSERT_NOW(a_mark_zero, out_valid && ((status == ST_NEW) || (status == ST_MERGED) || (status == ST_DROPPED)), (cell_value == '0) && !nothing_pending, "Mark item carries a value.")

endmodule

bind occupancy_grid_update_merger_unit ogm_checker u_ogm_checker (.*);
